### rtl/imdm_pkg.sv
// ----------------------------------------------------------------------------
// imdm_pkg
// shared types and constants of the integer multiply / divide / remainder unit
// ----------------------------------------------------------------------------
package imdm_pkg;

    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned LATENCY   = DIV_STEPS + 2;

    localparam logic [3:0] OP_MULT   = 4'd0;
    localparam logic [3:0] OP_MULTU  = 4'd1;
    localparam logic [3:0] OP_DIV    = 4'd2;
    localparam logic [3:0] OP_DIVU   = 4'd3;
    localparam logic [3:0] OP_MOD    = 4'd4;
    localparam logic [3:0] OP_MODU   = 4'd5;
    localparam logic [3:0] OP_DMULT  = 4'd6;
    localparam logic [3:0] OP_DMULTU = 4'd7;
    localparam logic [3:0] OP_DDIV   = 4'd8;
    localparam logic [3:0] OP_DDIVU  = 4'd9;
    localparam logic [3:0] OP_DMOD   = 4'd10;
    localparam logic [3:0] OP_DMODU  = 4'd11;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_MUL  = 2'd1,
        K_DIV  = 2'd2,
        K_REM  = 2'd3
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic        is32;
        logic        neg_q;
        logic        neg_r;
        logic        zero_div;
        logic [4:0]  dest;
    } t_ctl;

    typedef struct packed {
        t_ctl        ctl;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dsr;
        logic [63:0] pp0;
        logic [31:0] pp1;
        logic [31:0] pp2;
    } t_pipe;

endpackage

### rtl/imdm_prep.sv
// ----------------------------------------------------------------------------
// imdm_prep
// decode, operand sign handling and partial products, one register stage
// ----------------------------------------------------------------------------
module imdm_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [3:0]           i_opcode,
    input  logic [4:0]           i_dest_reg,
    input  logic [63:0]          i_operand_a,
    input  logic [63:0]          i_operand_b,
    output imdm_pkg::t_pipe      o_pipe
);
    imdm_pkg::t_pipe r_pipe;
    imdm_pkg::t_pipe n_pipe;
    logic            r_valid;

    logic [63:0] x;
    logic [63:0] y;
    logic        sgn;
    logic        is32;

    always_comb begin
        is32 = 1'b0;
        sgn  = 1'b0;
        n_pipe = '0;
        n_pipe.ctl.kind = imdm_pkg::K_NONE;
        case (i_opcode)
            imdm_pkg::OP_MULT, imdm_pkg::OP_MULTU: begin
                n_pipe.ctl.kind = imdm_pkg::K_MUL; is32 = 1'b1;
            end
            imdm_pkg::OP_DIV: begin
                n_pipe.ctl.kind = imdm_pkg::K_DIV; is32 = 1'b1; sgn = 1'b1;
            end
            imdm_pkg::OP_DIVU: begin
                n_pipe.ctl.kind = imdm_pkg::K_DIV; is32 = 1'b1;
            end
            imdm_pkg::OP_MOD: begin
                n_pipe.ctl.kind = imdm_pkg::K_REM; is32 = 1'b1; sgn = 1'b1;
            end
            imdm_pkg::OP_MODU: begin
                n_pipe.ctl.kind = imdm_pkg::K_REM; is32 = 1'b1;
            end
            imdm_pkg::OP_DMULT, imdm_pkg::OP_DMULTU: begin
                n_pipe.ctl.kind = imdm_pkg::K_MUL;
            end
            imdm_pkg::OP_DDIV: begin
                n_pipe.ctl.kind = imdm_pkg::K_DIV; sgn = 1'b1;
            end
            imdm_pkg::OP_DDIVU: begin
                n_pipe.ctl.kind = imdm_pkg::K_DIV;
            end
            imdm_pkg::OP_DMOD: begin
                n_pipe.ctl.kind = imdm_pkg::K_REM; sgn = 1'b1;
            end
            imdm_pkg::OP_DMODU: begin
                n_pipe.ctl.kind = imdm_pkg::K_REM;
            end
            default: begin
                n_pipe.ctl.kind = imdm_pkg::K_NONE;
            end
        endcase

        if (is32) begin
            x = sgn ? {{32{i_operand_a[31]}}, i_operand_a[31:0]}
                    : {32'd0, i_operand_a[31:0]};
            y = sgn ? {{32{i_operand_b[31]}}, i_operand_b[31:0]}
                    : {32'd0, i_operand_b[31:0]};
        end else begin
            x = i_operand_a;
            y = i_operand_b;
        end

        n_pipe.ctl.valid    = i_take;
        n_pipe.ctl.is32     = is32;
        n_pipe.ctl.neg_q    = sgn & (x[63] ^ y[63]);
        n_pipe.ctl.neg_r    = sgn & x[63];
        n_pipe.ctl.zero_div = (y == 64'd0);
        n_pipe.ctl.dest     = i_dest_reg;
        n_pipe.rem          = 64'd0;
        n_pipe.quo          = (sgn & x[63]) ? (64'd0 - x) : x;
        n_pipe.dsr          = (sgn & y[63]) ? (64'd0 - y) : y;
        n_pipe.pp0          = i_operand_a[31:0] * i_operand_b[31:0];
        n_pipe.pp1          = 32'(i_operand_a[31:0] * i_operand_b[63:32]);
        n_pipe.pp2          = 32'(i_operand_a[63:32] * i_operand_b[31:0]);
    end

    always_ff @(posedge i_clk) begin
        r_pipe <= n_pipe;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_comb begin
        o_pipe           = r_pipe;
        o_pipe.ctl.valid = r_valid;
    end

endmodule

### rtl/imdm_div_stage.sv
// ----------------------------------------------------------------------------
// imdm_div_stage
// one restoring divide step: one quotient bit per register stage
// ----------------------------------------------------------------------------
module imdm_div_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imdm_pkg::t_pipe      i_pipe,
    output imdm_pkg::t_pipe      o_pipe
);
    imdm_pkg::t_pipe r_pipe;
    imdm_pkg::t_pipe n_pipe;
    logic            r_valid;
    logic [64:0]     shifted;
    logic [64:0]     diff;

    always_comb begin
        n_pipe  = i_pipe;
        shifted = {i_pipe.rem, i_pipe.quo[63]};
        diff    = shifted - {1'b0, i_pipe.dsr};
        if (!diff[64]) begin
            n_pipe.rem = diff[63:0];
            n_pipe.quo = {i_pipe.quo[62:0], 1'b1};
        end else begin
            n_pipe.rem = shifted[63:0];
            n_pipe.quo = {i_pipe.quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe <= n_pipe;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_pipe.ctl.valid;
        end
    end

    always_comb begin
        o_pipe           = r_pipe;
        o_pipe.ctl.valid = r_valid;
    end

endmodule

### rtl/imdm_post.sv
// ----------------------------------------------------------------------------
// imdm_post
// sign fix-up, product sum, result select and output register
// ----------------------------------------------------------------------------
module imdm_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imdm_pkg::t_pipe      i_pipe,
    output logic                 o_done,
    output logic [63:0]          o_result_value,
    output logic                 o_write_enable,
    output logic [4:0]           o_dest_out
);
    logic        r_done;
    logic        r_we;
    logic [63:0] r_result;
    logic [4:0]  r_dest;
    logic [63:0] n_result;
    logic        n_we;
    logic [63:0] raw;
    logic [63:0] prod;

    always_comb begin
        prod = i_pipe.pp0 + {i_pipe.pp1 + i_pipe.pp2, 32'd0};
        case (i_pipe.ctl.kind)
            imdm_pkg::K_MUL: raw = prod;
            imdm_pkg::K_DIV: raw = i_pipe.ctl.zero_div ? 64'd0 :
                i_pipe.ctl.neg_q ? (64'd0 - i_pipe.quo) : i_pipe.quo;
            imdm_pkg::K_REM: raw = i_pipe.ctl.zero_div ? 64'd0 :
                i_pipe.ctl.neg_r ? (64'd0 - i_pipe.rem) : i_pipe.rem;
            default:         raw = 64'd0;
        endcase
        if (i_pipe.ctl.is32) begin
            raw = {{32{raw[31]}}, raw[31:0]};
        end
        n_we     = (i_pipe.ctl.kind != imdm_pkg::K_NONE) && (i_pipe.ctl.dest != 5'd0);
        n_result = n_we ? raw : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_dest   <= i_pipe.ctl.dest;
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_we   <= 1'b0;
        end else begin
            r_done <= i_pipe.ctl.valid;
            r_we   <= i_pipe.ctl.valid & n_we;
        end
    end

    assign o_done         = r_done;
    assign o_result_value = r_result;
    assign o_write_enable = r_we;
    assign o_dest_out     = r_dest;

endmodule

### rtl/int_mul_div_mod_unit.sv
// ----------------------------------------------------------------------------
// int_mul_div_mod_unit
// start reaches o_done via prep, divide stages and output register, all ops
// throughput: one operation per cycle; busy is never raised
// the 64 restoring divide steps, one register stage each, set the depth
// synchronous active-low reset empties the pipeline; nothing is strobed out
// ----------------------------------------------------------------------------
module int_mul_div_mod_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_opcode,
    input  logic [4:0]  i_dest_reg,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_done,
    output logic [63:0] o_result_value,
    output logic        o_write_enable,
    output logic [4:0]  o_dest_out
);
    imdm_pkg::t_pipe pipe [imdm_pkg::DIV_STEPS+1];

    assign busy = 1'b0;

    imdm_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (start & ~busy),
        .i_opcode    (i_opcode),
        .i_dest_reg  (i_dest_reg),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_pipe      (pipe[0])
    );

    for (genvar g = 0; g < imdm_pkg::DIV_STEPS; g++) begin : g_div
        imdm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pipe  (pipe[g]),
            .o_pipe  (pipe[g+1])
        );
    end

    imdm_post u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pipe         (pipe[imdm_pkg::DIV_STEPS]),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_write_enable (o_write_enable),
        .o_dest_out     (o_dest_out)
    );

endmodule

### rtl/imdm_checker.sv
// ----------------------------------------------------------------------------
// imdm_checker
// port-level checks of the multiply / divide unit, bound to the top level
// ----------------------------------------------------------------------------
module imdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [4:0]  i_dest_reg,
    input logic        o_done,
    input logic [63:0] o_result_value,
    input logic        o_write_enable,
    input logic [4:0]  o_dest_out
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##66 o_done) else $error("transfer result missing");

    a_dest_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start ##66 o_done) |-> o_dest_out == $past(i_dest_reg, 66))
        else $error("destination mismatch");

    a_zero_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dest_out == 5'd0) |-> (!o_write_enable && o_result_value == 64'd0))
        else $error("write to register zero");

    a_we_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> !o_write_enable) else $error("write enable without strobe");

endmodule

bind int_mul_div_mod_unit imdm_checker u_imdm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_dest_reg     (i_dest_reg),
    .o_done         (o_done),
    .o_result_value (o_result_value),
    .o_write_enable (o_write_enable),
    .o_dest_out     (o_dest_out)
);

### bench/tb_int_mul_div_mod_unit.sv
// ----------------------------------------------------------------------------
// tb_int_mul_div_mod_unit
// drives directed and random operations through the multiply / divide /
// remainder unit and checks every strobed result against a local predictor
// ----------------------------------------------------------------------------
module tb_int_mul_div_mod_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [3:0]  op;
        logic [4:0]  rd;
        logic [63:0] a;
        logic [63:0] b;
    } t_op_item;

    typedef struct {
        logic [63:0] value;
        logic        we;
        logic [4:0]  rd;
    } t_wb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_opcode = '0;
    logic [4:0]  i_dest_reg = '0;
    logic [63:0] i_operand_a = '0;
    logic [63:0] i_operand_b = '0;
    logic        o_done;
    logic [63:0] o_result_value;
    logic        o_write_enable;
    logic [4:0]  o_dest_out;

    t_op_item pending_ops[$];
    t_wb      expected_wb[$];
    int       send_idle_pct = 20;
    bit       hold_send = 1'b0;
    bit       stim_done = 1'b0;
    int       mismatches = 0;
    int       idle_cycles = 0;

    int_mul_div_mod_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] sx32(logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] smag(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] signed_quo(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        q = smag(a) / smag(b);
        return (a[63] ^ b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] signed_rem(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = smag(a) % smag(b);
        return a[63] ? -r : r;
    endfunction

    function automatic t_wb predict_writeback(t_op_item it);
        t_wb w;
        logic [63:0] sa, sb, ua, ub, r;
        logic ok;
        sa = sx32(it.a);
        sb = sx32(it.b);
        ua = {32'd0, it.a[31:0]};
        ub = {32'd0, it.b[31:0]};
        r = '0;
        ok = 1'b1;
        case (it.op)
            imdm_pkg::OP_MULT, imdm_pkg::OP_MULTU: r = sx32(ua * ub);
            imdm_pkg::OP_DIV:    r = (sb == 0) ? '0 : sx32(signed_quo(sa, sb));
            imdm_pkg::OP_DIVU:   r = (ub == 0) ? '0 : sx32(ua / ub);
            imdm_pkg::OP_MOD:    r = (sb == 0) ? '0 : sx32(signed_rem(sa, sb));
            imdm_pkg::OP_MODU:   r = (ub == 0) ? '0 : sx32(ua % ub);
            imdm_pkg::OP_DMULT, imdm_pkg::OP_DMULTU: r = it.a * it.b;
            imdm_pkg::OP_DDIV:   r = (it.b == 0) ? '0 : signed_quo(it.a, it.b);
            imdm_pkg::OP_DDIVU:  r = (it.b == 0) ? '0 : it.a / it.b;
            imdm_pkg::OP_DMOD:   r = (it.b == 0) ? '0 : signed_rem(it.a, it.b);
            imdm_pkg::OP_DMODU:  r = (it.b == 0) ? '0 : it.a % it.b;
            default:   ok = 1'b0;
        endcase
        w.we = ok && (it.rd != 0);
        w.value = w.we ? r : '0;
        w.rd = it.rd;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return {32'd0, $urandom()};
            5: return sx32({32'd0, $urandom()});
            6: return {32'd0, 32'h8000_0000};
            7: return 64'($urandom_range(0, 20));
            default: return rand64();
        endcase
    endfunction

    task automatic queue_op(logic [3:0] op, logic [4:0] rd, logic [63:0] a, logic [63:0] b);
        t_op_item it;
        it.op = op;
        it.rd = rd;
        it.a = a;
        it.b = b;
        pending_ops.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_wb.push_back(predict_writeback('{i_opcode, i_dest_reg,
                                                      i_operand_a, i_operand_b}));
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (pending_ops.size() != 0 && !hold_send
                     && $urandom_range(0, 99) >= send_idle_pct) begin
            t_op_item it;
            it = pending_ops.pop_front();
            start <= 1'b1;
            i_opcode <= it.op;
            i_dest_reg <= it.rd;
            i_operand_a <= it.a;
            i_operand_b <= it.b;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_wb.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: value %h", o_result_value);
            end else begin
                t_wb w;
                w = expected_wb.pop_front();
                if (w.value !== o_result_value || w.we !== o_write_enable
                    || w.rd !== o_dest_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h we %b rd %0d, got %h we %b rd %0d",
                                 w.value, w.we, w.rd, o_result_value,
                                 o_write_enable, o_dest_out);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n || hold_send
            || (pending_ops.size() == 0 && expected_wb.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] edge_vals[6];
        int n;
        edge_vals = '{64'd0, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                      64'h7fff_ffff_ffff_ffff, 64'h0000_0000_8000_0000,
                      64'hffff_ffff_8000_0000};
        // every operation, overflow, zero divisor, unused codes, destination zero
        for (int op = 0; op < 12; op++)
            queue_op(4'(op), 5'(op + 1), edge_vals[op % 6], edge_vals[(op + 1) % 6]);
        queue_op(imdm_pkg::OP_DDIV, 5'd31, 64'h8000_0000_0000_0000, '1);
        queue_op(imdm_pkg::OP_DMOD, 5'd30, 64'h8000_0000_0000_0000, '1);
        queue_op(imdm_pkg::OP_DIV, 5'd29, 64'h0000_0000_8000_0000, 64'h1234_5678_ffff_ffff);
        queue_op(imdm_pkg::OP_MOD, 5'd28, 64'h0000_0000_8000_0000, 64'h0000_0000_ffff_ffff);
        queue_op(imdm_pkg::OP_DDIVU, 5'd27, '1, '0);
        queue_op(imdm_pkg::OP_DIVU, 5'd26, '1, 64'hffff_ffff_0000_0000);
        queue_op(imdm_pkg::OP_DMODU, 5'd0, '1, 64'd7);
        queue_op(4'd12, 5'd5, '1, 64'd3);
        queue_op(4'd15, 5'd31, '1, '1);
        queue_op(imdm_pkg::OP_MOD, 5'd25, 64'hffff_ffff_ffff_fff9, 64'd2);
        queue_op(imdm_pkg::OP_DMULT, 5'd24, '1, '1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        n = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 52 : 0;
            for (int k = 0; k < 430; k++) begin
                if ($urandom_range(0, 19) == 0)
                    queue_op(4'($urandom_range(12, 15)), 5'($urandom()),
                             rand64(), rand64());
                else
                    queue_op(4'($urandom_range(0, 11)),
                             ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom()),
                             pick_operand(), pick_operand());
            end
            while (pending_ops.size() != 0) @(posedge i_clk);
            if (phase == 1) begin
                // hold off until the pipeline has drained completely
                hold_send = 1'b1;
                while (expected_wb.size() != 0 || start) @(posedge i_clk);
                hold_send = 1'b0;
            end
        end

        while (start || expected_wb.size() != 0) begin
            @(posedge i_clk);
            n++;
            if (n > WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
        stim_done = 1'b1;
        repeat (imdm_pkg::LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_wb.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
